FILE: rtl/pal_pkg.sv
// Package for the path arc-length resampler: payload structs, sequencer states
// and sizing constants. No dependencies.
`default_nettype none
package pal_pkg;

  localparam int MaxStepsDefault = 63;
  localparam int QueueDepth      = 2;
  localparam int CoordW          = 32;
  localparam int HeadW           = 16;
  localparam int StepW           = 24;
  localparam int RunW            = 34;
  localparam int CfgAddrW        = 3;
  localparam int CfgDataW        = 32;
  localparam logic [StepW-1:0] StepReset = 24'd4096;

  // Register indexes (paddr[2] selects)
  localparam logic RegStepLength = 1'b0;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [HeadW-1:0]  heading;
    logic                     is_last;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic signed [HeadW-1:0]  out_heading;
    logic                     end_of_path;
    logic                     overflow;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_SQX,
    S_SQY,
    S_SUM,
    S_SQRT,
    S_LEN,
    S_COUNT,
    S_PT,
    S_DIV,
    S_MUL,
    S_ADD,
    S_EMIT_PT,
    S_FIN,
    S_FINAL
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/path_arc_length_resampler.sv
// Path arc-length resampler: a first point is emitted as it is; a later point goes
// through its segment length (square root), then the step count (n steps reached,
// capped at MAX_STEPS+1), then each emitted point, a finish step and, where due, a
// final point, each emit held by any output stall. One item at a time, set by pal_back;
// a two-entry input queue and the output register let either side stall on its own.
// Synchronous active-low reset clears path state; the step register resets to 4096.
`default_nettype none
module path_arc_length_resampler #(
  parameter int MAX_STEPS = pal_pkg::MaxStepsDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire pal_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output pal_pkg::out_t                       out_data,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [pal_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  wire logic [pal_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [pal_pkg::CfgDataW-1:0]        cfg_prdata,
  output logic                                cfg_pready
);

  logic [pal_pkg::StepW-1:0] step_r;
  logic                      q_valid, q_pop;
  pal_pkg::in_t              q_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == pal_pkg::RegStepLength) ?
                      pal_pkg::CfgDataW'(step_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pal_pkg::StepReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == pal_pkg::RegStepLength) begin
      step_r <= cfg_pwdata[pal_pkg::StepW-1:0];
    end
  end

  pal_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  pal_back #(
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_cfg    (step_r),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/pal_front.sv
// Input side of the resampler: accepts path points into a short queue.
// Depends on pal_pkg.
`default_nettype none
module pal_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pal_pkg::in_t  in_data,
  input  wire logic          q_pop,
  output logic               q_valid,
  output pal_pkg::in_t       q_data
);

  localparam int PtrW = $clog2(pal_pkg::QueueDepth);
  localparam int CntW = $clog2(pal_pkg::QueueDepth + 1);

  pal_pkg::in_t    mem_r [pal_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            push, pop;

  assign in_stall = (cnt_r == CntW'(pal_pkg::QueueDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= in_data;
        wr_ptr_r        <= (wr_ptr_r == PtrW'(pal_pkg::QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(pal_pkg::QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CntW'(push) - CntW'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pal_back.sv
// Sequencer of the resampler: segment length by square root, step count,
// ratio division and interpolation, one result transaction at a time.
// Depends on pal_pkg.
`default_nettype none
module pal_back #(
  parameter int MAX_STEPS = pal_pkg::MaxStepsDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [pal_pkg::StepW-1:0]   step_cfg,
  input  wire logic                        q_valid,
  input  wire pal_pkg::in_t                q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output pal_pkg::out_t                    out_data
);

  localparam int CW      = $clog2(MAX_STEPS + 2);
  localparam int CntLim  = MAX_STEPS + 1;

  pal_pkg::state_t state_r, state_nxt;

  pal_pkg::in_t        cur_r, cur_nxt;
  logic                have_r, have_nxt;
  logic signed [31:0]  prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt, prev_z_r, prev_z_nxt;
  logic signed [15:0]  prev_h_r, prev_h_nxt;
  logic [33:0]         run_r, run_nxt, r_old_r, r_old_nxt;
  logic signed [31:0]  emit_x_r, emit_x_nxt, emit_y_r, emit_y_nxt;
  logic signed [32:0]  dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic signed [15:0]  dh_r, dh_nxt;
  logic [65:0]         prod_r, prod_nxt, sx_r, sx_nxt, rad_r, rad_nxt;
  logic [34:0]         rem_r, rem_nxt;
  logic [32:0]         root_r, root_nxt, len_r, len_nxt, dre_r, dre_nxt;
  logic [5:0]          it_r, it_nxt;
  logic [34:0]         acc_r, acc_nxt;
  logic [35:0]         pos_r, pos_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt, m_r, m_nxt, k_r, k_nxt;
  logic                ovf_r, ovf_nxt;
  logic [30:0]         dlo_r, dlo_nxt, q_r, q_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic signed [31:0]  px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic signed [15:0]  ph_r, ph_nxt;
  logic                out_valid_r, out_valid_nxt;
  pal_pkg::out_t       out_r, out_nxt;

  logic                out_free;
  logic [23:0]         step_eff;
  logic [32:0]         mul_a, mul_b, mag;
  logic                dneg;
  logic [35:0]         pstep, diff, rbase, qv, lres;
  logic [32:0]         num;
  logic [63:0]         dvd;
  logic [36:0]         rem2, trial;
  logic [33:0]         r2;
  logic [65:0]         rnd;
  logic                count_go, last_pt, same_xy;

  assign out_free  = !out_valid_r || !out_stall;
  assign step_eff  = (step_cfg == '0) ? 24'd1 : step_cfg;
  assign pstep     = pos_r + 36'(step_eff);
  assign count_go  = (cnt_r != CW'(CntLim)) && (pstep <= {1'b0, acc_r});
  assign last_pt   = (k_r == m_r);
  assign same_xy   = (px_r == cur_r.pos_x) && (py_r == cur_r.pos_y);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Shared multiplier operand select
  always_comb begin
    case (idx_r)
      2'd0:    begin mag = dx_r[32] ? 33'(-dx_r) : 33'(dx_r); dneg = dx_r[32]; end
      2'd1:    begin mag = dy_r[32] ? 33'(-dy_r) : 33'(dy_r); dneg = dy_r[32]; end
      2'd2:    begin mag = dz_r[32] ? 33'(-dz_r) : 33'(dz_r); dneg = dz_r[32]; end
      default: begin
        mag  = dh_r[15] ? 33'(-$signed({dh_r[15], dh_r})) : 33'(dh_r);
        dneg = dh_r[15];
      end
    endcase
    case (idx_r)
      2'd0:    rbase = 36'(prev_x_r);
      2'd1:    rbase = 36'(prev_y_r);
      2'd2:    rbase = 36'(prev_z_r);
      default: rbase = 36'(prev_h_r);
    endcase
    if (state_r == pal_pkg::S_SQX) begin
      mul_a = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
    end else if (state_r == pal_pkg::S_SQY) begin
      mul_a = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
    end else begin
      mul_a = mag;
    end
    mul_b = (state_r == pal_pkg::S_MUL) ? {2'b00, q_r} : mul_a;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pal_pkg::S_IDLE:    if (q_valid) state_nxt = have_r ? pal_pkg::S_SQX : pal_pkg::S_FIRST;
      pal_pkg::S_FIRST:   if (out_free) state_nxt = pal_pkg::S_IDLE;
      pal_pkg::S_SQX:     state_nxt = pal_pkg::S_SQY;
      pal_pkg::S_SQY:     state_nxt = pal_pkg::S_SUM;
      pal_pkg::S_SUM:     state_nxt = pal_pkg::S_SQRT;
      pal_pkg::S_SQRT:    if (it_r == 6'd32) state_nxt = pal_pkg::S_LEN;
      pal_pkg::S_LEN:     state_nxt = (root_r == '0) ? pal_pkg::S_FIN : pal_pkg::S_COUNT;
      pal_pkg::S_COUNT: begin
        if (!count_go) begin
          state_nxt = (cnt_r == '0) ? pal_pkg::S_FIN : pal_pkg::S_PT;
        end
      end
      pal_pkg::S_PT:      state_nxt = pal_pkg::S_DIV;
      pal_pkg::S_DIV:     if (it_r == 6'd30) state_nxt = pal_pkg::S_MUL;
      pal_pkg::S_MUL:     state_nxt = pal_pkg::S_ADD;
      pal_pkg::S_ADD:     state_nxt = (idx_r == 2'd3) ? pal_pkg::S_EMIT_PT : pal_pkg::S_MUL;
      pal_pkg::S_EMIT_PT: if (out_free) state_nxt = last_pt ? pal_pkg::S_FIN : pal_pkg::S_PT;
      pal_pkg::S_FIN: begin
        if (cur_r.is_last && (emit_x_r != cur_r.pos_x || emit_y_r != cur_r.pos_y)) begin
          state_nxt = pal_pkg::S_FINAL;
        end else begin
          state_nxt = pal_pkg::S_IDLE;
        end
      end
      pal_pkg::S_FINAL:   if (out_free) state_nxt = pal_pkg::S_IDLE;
      default:            state_nxt = pal_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cur_nxt = cur_r; have_nxt = have_r;
    prev_x_nxt = prev_x_r; prev_y_nxt = prev_y_r; prev_z_nxt = prev_z_r; prev_h_nxt = prev_h_r;
    run_nxt = run_r; r_old_nxt = r_old_r; emit_x_nxt = emit_x_r; emit_y_nxt = emit_y_r;
    dx_nxt = dx_r; dy_nxt = dy_r; dz_nxt = dz_r; dh_nxt = dh_r;
    prod_nxt = mul_a * mul_b;
    sx_nxt = sx_r; rad_nxt = rad_r; rem_nxt = rem_r; root_nxt = root_r; len_nxt = len_r;
    dre_nxt = dre_r; it_nxt = it_r; acc_nxt = acc_r; pos_nxt = pos_r;
    cnt_nxt = cnt_r; m_nxt = m_r; k_nxt = k_r; ovf_nxt = ovf_r;
    dlo_nxt = dlo_r; q_nxt = q_r; idx_nxt = idx_r;
    px_nxt = px_r; py_nxt = py_r; pz_nxt = pz_r; ph_nxt = ph_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop = 1'b0;
    rem2  = {rem_r, rad_r[65:64]};
    trial = {2'b00, root_r, 2'b01};
    diff  = (pstep > 36'(r_old_r)) ? pstep - 36'(r_old_r) : '0;
    num   = (diff > 36'(len_r)) ? len_r : diff[32:0];
    dvd   = (64'(num) << 30) + 64'(len_r[32:1]);
    r2    = {dre_r, dlo_r[30]};
    rnd   = prod_r + 66'(1 << 29);
    qv    = rnd[65:30];
    lres  = dneg ? rbase - qv : rbase + qv;

    unique case (state_r)
      pal_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_data;
          ovf_nxt = 1'b0;
          dx_nxt  = 33'(q_data.pos_x) - 33'(prev_x_r);
          dy_nxt  = 33'(q_data.pos_y) - 33'(prev_y_r);
          dz_nxt  = 33'(q_data.pos_z) - 33'(prev_z_r);
          dh_nxt  = q_data.heading - prev_h_r;
        end
      end
      pal_pkg::S_FIRST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{cur_r.pos_x, cur_r.pos_y, cur_r.pos_z, cur_r.heading, cur_r.is_last, 1'b0};
          if (cur_r.is_last) begin
            emit_x_nxt = '0; emit_y_nxt = '0;
          end else begin
            emit_x_nxt = cur_r.pos_x; emit_y_nxt = cur_r.pos_y;
            have_nxt = 1'b1;
            prev_x_nxt = cur_r.pos_x; prev_y_nxt = cur_r.pos_y;
            prev_z_nxt = cur_r.pos_z; prev_h_nxt = cur_r.heading;
            run_nxt = '0;
          end
        end
      end
      pal_pkg::S_SQX: ;
      pal_pkg::S_SQY: sx_nxt = prod_r;
      pal_pkg::S_SUM: begin
        rad_nxt = sx_r + prod_r;
        rem_nxt = '0; root_nxt = '0; it_nxt = '0;
      end
      pal_pkg::S_SQRT: begin
        rad_nxt = {rad_r[63:0], 2'b00};
        it_nxt  = it_r + 1'b1;
        if (rem2 >= trial) begin
          rem_nxt  = 35'(rem2 - trial);
          root_nxt = {root_r[31:0], 1'b1};
        end else begin
          rem_nxt  = rem2[34:0];
          root_nxt = {root_r[31:0], 1'b0};
        end
      end
      pal_pkg::S_LEN: begin
        len_nxt   = root_r;
        r_old_nxt = run_r;
        acc_nxt   = 35'(run_r) + 35'(root_r);
        pos_nxt   = '0;
        cnt_nxt   = '0;
      end
      pal_pkg::S_COUNT: begin
        if (count_go) begin
          pos_nxt = pstep;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          if (cnt_r == CW'(CntLim)) begin
            ovf_nxt = 1'b1;
            m_nxt   = CW'(MAX_STEPS);
            run_nxt = '0;
          end else begin
            m_nxt   = cnt_r;
            run_nxt = 34'(36'(acc_r) - pos_r);
          end
          pos_nxt = '0;
          k_nxt   = '0;
        end
      end
      pal_pkg::S_PT: begin
        pos_nxt = pstep;
        k_nxt   = k_r + 1'b1;
        dre_nxt = dvd[63:31];
        dlo_nxt = dvd[30:0];
        it_nxt  = '0;
      end
      pal_pkg::S_DIV: begin
        dlo_nxt = {dlo_r[29:0], 1'b0};
        it_nxt  = it_r + 1'b1;
        idx_nxt = '0;
        if (r2 >= {1'b0, len_r}) begin
          dre_nxt = 33'(r2 - {1'b0, len_r});
          q_nxt   = {q_r[29:0], 1'b1};
        end else begin
          dre_nxt = r2[32:0];
          q_nxt   = {q_r[29:0], 1'b0};
        end
      end
      pal_pkg::S_MUL: ;
      pal_pkg::S_ADD: begin
        idx_nxt = idx_r + 1'b1;
        case (idx_r)
          2'd0:    px_nxt = lres[31:0];
          2'd1:    py_nxt = lres[31:0];
          2'd2:    pz_nxt = lres[31:0];
          default: ph_nxt = lres[15:0];
        endcase
      end
      pal_pkg::S_EMIT_PT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{px_r, py_r, pz_r, ph_r, cur_r.is_last && last_pt && same_xy, ovf_r};
          emit_x_nxt = px_r;
          emit_y_nxt = py_r;
        end
      end
      pal_pkg::S_FIN: begin
        prev_x_nxt = cur_r.pos_x; prev_y_nxt = cur_r.pos_y;
        prev_z_nxt = cur_r.pos_z; prev_h_nxt = cur_r.heading;
        if (cur_r.is_last && emit_x_r == cur_r.pos_x && emit_y_r == cur_r.pos_y) begin
          have_nxt = 1'b0; run_nxt = '0; emit_x_nxt = '0; emit_y_nxt = '0;
          prev_x_nxt = '0; prev_y_nxt = '0; prev_z_nxt = '0; prev_h_nxt = '0;
        end
      end
      pal_pkg::S_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{cur_r.pos_x, cur_r.pos_y, cur_r.pos_z, cur_r.heading, 1'b1, ovf_r};
          have_nxt = 1'b0; run_nxt = '0; emit_x_nxt = '0; emit_y_nxt = '0;
          prev_x_nxt = '0; prev_y_nxt = '0; prev_z_nxt = '0; prev_h_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pal_pkg::S_IDLE;
      have_r      <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
      prev_h_r    <= '0;
      run_r       <= '0;
      emit_x_r    <= '0;
      emit_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_r      <= have_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      prev_z_r    <= prev_z_nxt;
      prev_h_r    <= prev_h_nxt;
      run_r       <= run_nxt;
      emit_x_r    <= emit_x_nxt;
      emit_y_r    <= emit_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;  r_old_r <= r_old_nxt;
    dx_r <= dx_nxt;    dy_r <= dy_nxt;   dz_r <= dz_nxt;   dh_r <= dh_nxt;
    prod_r <= prod_nxt; sx_r <= sx_nxt;  rad_r <= rad_nxt; rem_r <= rem_nxt;
    root_r <= root_nxt; len_r <= len_nxt; dre_r <= dre_nxt; it_r <= it_nxt;
    acc_r <= acc_nxt;  pos_r <= pos_nxt; cnt_r <= cnt_nxt; m_r <= m_nxt;
    k_r <= k_nxt;      ovf_r <= ovf_nxt; dlo_r <= dlo_nxt; q_r <= q_nxt;
    idx_r <= idx_nxt;  px_r <= px_nxt;   py_r <= py_nxt;   pz_r <= pz_nxt;
    ph_r <= ph_nxt;    out_r <= out_nxt;
  end

endmodule
`default_nettype wire
